### rtl/core/mvts_pkg.sv
// shared types and constants for the multi-voice tone synthesizer
// item structs, slot layout, controller command and datapath status groups
`default_nettype none

package mvts_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_END     = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_ASK     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_FULL   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ADDR_HEAD = 2'd0,
    ADDR_TAIL = 2'd1,
    ADDR_ASK  = 2'd2
  } addr_sel_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629711;
  localparam logic signed [33:0] SAMPLE_MAX = 34'sd8388607;
  localparam logic signed [33:0] SAMPLE_MIN = -34'sd8388608;
  localparam logic [38:0] TOTAL_MAX = 39'h0F_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         voice;
    logic [30:0]        phase_step;
    logic [15:0]        note_gain;
    logic signed [15:0] balance;
    logic [31:0]        length_samples;
    logic [23:0]        rise_samples;
    logic [23:0]        fall_samples;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
    logic [35:0]        remaining_total;
  } out_item_t;

  typedef struct packed {
    logic [30:0]        phase_step;
    logic [15:0]        gain;
    logic signed [15:0] balance;
    logic [31:0]        remaining;
    logic [23:0]        rise;
    logic [23:0]        fall;
  } slot_t;

  typedef struct packed {
    logic      capture;
    logic      tick_start;
    logic      ram_rd;
    addr_sel_t addr_sel;
    logic      load_mag;
    logic      start_atk;
    logic      start_rel;
    logic      div_step;
    logic      load_pan;
    logic      acc_voice;
    logic      next_voice;
    logic      cut_wb;
    logic      append;
    logic      clear_all;
    logic      ask_start;
    logic      ask_acc;
    logic      load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       voice_ok;
    logic       len_zero;
    logic       voice_busy;
    logic       queue_full;
    logic       last_voice;
    logic       atk_need;
    logic       rel_need;
    logic       div_last;
    logic       ask_more;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/mvts_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mvts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/mvts_sine_rom.sv
// constant sine magnitude table over one quarter wave, registered read
// depends on mvts_pkg for the fixed-point pi/2 constant
`default_nettype none

module mvts_sine_rom #(
  parameter int SINE_TABLE_SIZE = 1024,
  localparam int RW = $clog2(SINE_TABLE_SIZE + 1)
) (
  input  wire logic          clk,
  input  wire logic [RW-1:0] addr,
  output logic      [14:0]   mag_q
);
  import mvts_pkg::*;

  function automatic logic [14:0] sine_mag(input int r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x = 64'(r) * HALF_PI_Q30 / SINE_TABLE_SIZE;
    x2 = (x * x) >> 30;
    sum = $signed(x);
    term = ((x * x2) >> 30) / 6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return 15'(sum);
  endfunction

  logic [14:0] lut [SINE_TABLE_SIZE + 1];

  for (genvar g = 0; g <= SINE_TABLE_SIZE; g++) begin : g_lut
    assign lut[g] = sine_mag(g);
  end

  always_ff @(posedge clk) begin
    mag_q <= lut[addr];
  end

endmodule

`default_nettype wire

### rtl/core/mvts_ctrl.sv
// sequencing state machine: decodes items, walks voices, runs the divider
// depends on mvts_pkg for command and status groups
`default_nettype none

module mvts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mvts_pkg::dp_stat_t st,
  output mvts_pkg::ctl_cmd_t      cmd
);
  import mvts_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DECODE  = 16'h0002,
    S_CUT_RD  = 16'h0004,
    S_CUT_WB  = 16'h0008,
    S_APPEND  = 16'h0010,
    S_TK_RD   = 16'h0020,
    S_TK_MAG  = 16'h0040,
    S_TK_ATK  = 16'h0080,
    S_DIV_A   = 16'h0100,
    S_TK_REL  = 16'h0200,
    S_DIV_R   = 16'h0400,
    S_TK_PAN  = 16'h0800,
    S_TK_ACC  = 16'h1000,
    S_ASK_RD  = 16'h2000,
    S_ASK_ACC = 16'h4000,
    S_EMIT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   more_note;

  assign more_note = (st.action == ACT_REPLACE) && !st.len_zero;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_HEAD;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.action)
          ACT_TICK: begin
            cmd.tick_start = 1'b1;
            state_nxt      = S_TK_RD;
          end
          ACT_ADD: begin
            state_nxt = (!st.voice_ok || st.len_zero) ? S_IDLE : S_APPEND;
          end
          ACT_REPLACE, ACT_END: begin
            state_nxt = st.voice_ok ? S_CUT_RD : S_IDLE;
          end
          ACT_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = S_IDLE;
          end
          ACT_ASK: begin
            cmd.ask_start = 1'b1;
            state_nxt     = S_ASK_RD;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CUT_RD: begin
        if (st.voice_busy) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_CUT_WB;
        end else begin
          state_nxt = more_note ? S_APPEND : S_IDLE;
        end
      end
      S_CUT_WB: begin
        cmd.cut_wb = 1'b1;
        state_nxt  = more_note ? S_APPEND : S_IDLE;
      end
      S_APPEND: begin
        cmd.addr_sel = ADDR_TAIL;
        if (st.queue_full) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_TK_RD: begin
        if (st.voice_busy) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_TK_MAG;
        end else begin
          cmd.next_voice = 1'b1;
          if (st.last_voice) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_TK_MAG: begin
        cmd.load_mag = 1'b1;
        state_nxt    = S_TK_ATK;
      end
      S_TK_ATK: begin
        if (st.atk_need) begin
          cmd.start_atk = 1'b1;
          state_nxt     = S_DIV_A;
        end else begin
          state_nxt = S_TK_REL;
        end
      end
      S_DIV_A: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_TK_REL;
        end
      end
      S_TK_REL: begin
        if (st.rel_need) begin
          cmd.start_rel = 1'b1;
          state_nxt     = S_DIV_R;
        end else begin
          state_nxt = S_TK_PAN;
        end
      end
      S_DIV_R: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_TK_PAN;
        end
      end
      S_TK_PAN: begin
        cmd.load_pan = 1'b1;
        state_nxt    = S_TK_ACC;
      end
      S_TK_ACC: begin
        cmd.acc_voice  = 1'b1;
        cmd.next_voice = 1'b1;
        state_nxt      = st.last_voice ? S_EMIT : S_TK_RD;
      end
      S_ASK_RD: begin
        cmd.addr_sel = ADDR_ASK;
        if (st.ask_more) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_ASK_ACC;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_ASK_ACC: begin
        cmd.ask_acc = 1'b1;
        state_nxt   = S_ASK_RD;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mvts_dpath.sv
// datapath: voice state, note slot ram, sine table, mixer, divider, result register
// depends on mvts_pkg, mvts_ram and mvts_sine_rom
`default_nettype none

module mvts_dpath #(
  parameter int VOICE_COUNT     = 8,
  parameter int QUEUE_DEPTH     = 8,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mvts_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mvts_pkg::out_item_t      out_item,
  input  wire mvts_pkg::ctl_cmd_t  cmd,
  output mvts_pkg::dp_stat_t       st
);
  import mvts_pkg::*;

  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = VOICE_COUNT * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW    = $clog2(SINE_TABLE_SIZE);
  localparam int RW    = $clog2(SINE_TABLE_SIZE + 1);
  localparam int QW    = IW + 3;
  localparam logic [QW-1:0] N1 = QW'(SINE_TABLE_SIZE);
  localparam logic [QW-1:0] N2 = QW'(2 * SINE_TABLE_SIZE);
  localparam logic [QW-1:0] N3 = QW'(3 * SINE_TABLE_SIZE);

  // per-voice state
  logic [HW-1:0] head_r    [VOICE_COUNT];
  logic [CW-1:0] count_r   [VOICE_COUNT];
  logic [31:0]   phase_r   [VOICE_COUNT];
  logic [31:0]   elapsed_r [VOICE_COUNT];

  in_item_t item_r;
  logic [VW-1:0] vidx_r;
  logic [CW-1:0] k_r;
  logic [30:0]   mag_r;
  logic          neg_r;
  logic          neg_q_r;
  logic [62:0]   num_r;
  logic [23:0]   rem_r;
  logic [23:0]   den_r;
  logic [5:0]    cnt_r;
  logic [24:0]   cl_r, cr_r;
  logic signed [33:0] acc_l_r, acc_r_r;
  logic [38:0]   total_r;
  logic          out_valid_r;
  out_item_t     out_item_r;
  out_item_t     out_item_nxt;

  logic          is_tick;
  logic [VW-1:0] cur_v;
  logic          v_ok_range;
  logic          voice_ok;
  logic [HW-1:0] cur_head;
  logic [CW-1:0] cur_cnt;
  logic [31:0]   cur_elapsed;
  logic [31:0]   cur_phase;
  logic [CW-1:0] k_sel;
  logic [CW:0]   off_sum;
  logic [CW:0]   off_mod;
  logic [AW-1:0] slot_addr;
  slot_t         ram_q;
  slot_t         wdata;
  logic          ram_we;
  logic [IW-1:0] idx;
  logic [QW-1:0] qv;
  logic [1:0]    quad;
  logic [QW-1:0] remq;
  logic [RW-1:0] rom_addr;
  logic [14:0]   rom_q;
  logic [24:0]   div_sh;
  logic          div_ge;
  logic [62:0]   num_nxt;
  logic [23:0]   rem_nxt;
  logic signed [17:0] wl, wr;
  logic [47:0]   pl, pr;
  logic [31:0]   cut_rem;
  logic [HW:0]   head_inc;

  assign is_tick    = (item_r.action == ACT_TICK);
  assign cur_v      = is_tick ? vidx_r : VW'(item_r.voice);
  assign voice_ok   = (32'(item_r.voice) < 32'(VOICE_COUNT));
  assign v_ok_range = is_tick || voice_ok;
  assign cur_head    = v_ok_range ? head_r[cur_v] : '0;
  assign cur_cnt     = v_ok_range ? count_r[cur_v] : '0;
  assign cur_elapsed = v_ok_range ? elapsed_r[cur_v] : '0;
  assign cur_phase   = phase_r[vidx_r];

  // slot address: voice base plus (head + k) modulo depth
  always_comb begin
    case (cmd.addr_sel)
      ADDR_TAIL: k_sel = cur_cnt;
      ADDR_ASK:  k_sel = k_r;
      default:   k_sel = '0;
    endcase
    off_sum = (CW+1)'(cur_head) + (CW+1)'(k_sel);
    off_mod = (off_sum >= (CW+1)'(QUEUE_DEPTH)) ? off_sum - (CW+1)'(QUEUE_DEPTH) : off_sum;
    slot_addr = AW'(AW'(cur_v) * AW'(QUEUE_DEPTH) + AW'(off_mod));
  end

  // sine index folding into a quarter-wave table address
  always_comb begin
    idx = IW'((64'(cur_phase) * 64'(SINE_TABLE_SIZE)) >> 32);
    qv  = QW'({idx, 2'b00});
    if (qv >= N3) begin
      quad = 2'd3;
      remq = qv - N3;
    end else if (qv >= N2) begin
      quad = 2'd2;
      remq = qv - N2;
    end else if (qv >= N1) begin
      quad = 2'd1;
      remq = qv - N1;
    end else begin
      quad = 2'd0;
      remq = qv;
    end
    rom_addr = quad[0] ? RW'(N1 - remq) : RW'(remq);
  end

  mvts_sine_rom #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_rom (
    .clk   (clk),
    .addr  (rom_addr),
    .mag_q (rom_q)
  );

  // slot write data
  always_comb begin
    cut_rem = (32'(ram_q.fall) < ram_q.remaining) ? 32'(ram_q.fall) : ram_q.remaining;
    wdata   = ram_q;
    ram_we  = 1'b0;
    if (cmd.cut_wb) begin
      wdata.remaining = cut_rem;
      ram_we          = 1'b1;
    end else if (cmd.append) begin
      wdata.phase_step = item_r.phase_step;
      wdata.gain       = item_r.note_gain;
      wdata.balance    = item_r.balance;
      wdata.remaining  = item_r.length_samples;
      wdata.rise       = item_r.rise_samples;
      wdata.fall       = item_r.fall_samples;
      ram_we           = 1'b1;
    end else if (cmd.acc_voice) begin
      wdata.remaining = ram_q.remaining - 32'd1;
      ram_we          = (ram_q.remaining > 32'd1);
    end
  end

  mvts_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_addr),
    .wdata (wdata),
    .re    (cmd.ram_rd),
    .raddr (slot_addr),
    .rdata (ram_q)
  );

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    div_sh  = {rem_r, num_r[62]};
    div_ge  = (div_sh >= {1'b0, den_r});
    rem_nxt = div_ge ? 24'(div_sh - {1'b0, den_r}) : div_sh[23:0];
    num_nxt = {num_r[61:0], div_ge};
  end

  always_comb begin
    wl = 18'sd32768 - 18'(ram_q.balance);
    wr = 18'sd32768 + 18'(ram_q.balance);
    pl = 48'(mag_r) * 48'(wl[16:0]);
    pr = 48'(mag_r) * 48'(wr[16:0]);
  end

  assign head_inc = (HW+1)'(cur_head) + (HW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        head_r[i]    <= '0;
        count_r[i]   <= '0;
        phase_r[i]   <= '0;
        elapsed_r[i] <= '0;
      end
    end else begin
      if (cmd.cut_wb) begin
        count_r[cur_v] <= CW'(1);
      end
      if (cmd.append) begin
        if (cur_cnt == '0) begin
          phase_r[cur_v]   <= '0;
          elapsed_r[cur_v] <= '0;
        end
        count_r[cur_v] <= cur_cnt + CW'(1);
      end
      if (cmd.acc_voice) begin
        if (ram_q.remaining <= 32'd1) begin
          head_r[cur_v]    <= (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
          count_r[cur_v]   <= cur_cnt - CW'(1);
          phase_r[cur_v]   <= '0;
          elapsed_r[cur_v] <= '0;
        end else begin
          phase_r[cur_v] <= cur_phase + 32'(ram_q.phase_step);
          if (cur_elapsed != 32'hFFFF_FFFF) begin
            elapsed_r[cur_v] <= cur_elapsed + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_q_r <= quad[1];
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.tick_start) begin
      vidx_r  <= '0;
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (cmd.next_voice) begin
      vidx_r <= vidx_r + VW'(1);
    end
    if (cmd.load_mag) begin
      mag_r <= 31'(31'(rom_q) * 31'(ram_q.gain));
      neg_r <= neg_q_r;
    end
    if (cmd.start_atk) begin
      num_r <= 63'(64'(mag_r) * 64'(cur_elapsed));
      den_r <= ram_q.rise;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.start_rel) begin
      num_r <= 63'(64'(mag_r) * 64'(ram_q.remaining));
      den_r <= ram_q.fall;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd62) begin
        mag_r <= num_nxt[30:0];
      end
    end
    if (cmd.load_pan) begin
      cl_r <= pl[47:23];
      cr_r <= pr[47:23];
    end
    if (cmd.acc_voice) begin
      acc_l_r <= neg_r ? acc_l_r - $signed(34'(cl_r)) : acc_l_r + $signed(34'(cl_r));
      acc_r_r <= neg_r ? acc_r_r - $signed(34'(cr_r)) : acc_r_r + $signed(34'(cr_r));
    end
    if (cmd.ask_start) begin
      k_r     <= '0;
      total_r <= '0;
    end else if (cmd.ask_acc) begin
      k_r     <= k_r + CW'(1);
      total_r <= total_r + 39'(ram_q.remaining);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_item_nxt = '0;
    if (is_tick) begin
      out_item_nxt.kind = KIND_SAMPLE;
      out_item_nxt.left_sample = (acc_l_r > SAMPLE_MAX) ? 24'sh7FFFFF :
                                 (acc_l_r < SAMPLE_MIN) ? -24'sh800000 : acc_l_r[23:0];
      out_item_nxt.right_sample = (acc_r_r > SAMPLE_MAX) ? 24'sh7FFFFF :
                                  (acc_r_r < SAMPLE_MIN) ? -24'sh800000 : acc_r_r[23:0];
    end else if (item_r.action == ACT_ASK) begin
      out_item_nxt.kind = KIND_TIME;
      out_item_nxt.remaining_total = (total_r > TOTAL_MAX) ? TOTAL_MAX[35:0] : total_r[35:0];
    end else begin
      out_item_nxt.kind = KIND_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    st.action     = item_r.action;
    st.voice_ok   = voice_ok;
    st.len_zero   = (item_r.length_samples == 32'd0);
    st.voice_busy = (cur_cnt != '0);
    st.queue_full = (cur_cnt >= CW'(QUEUE_DEPTH));
    st.last_voice = (vidx_r == VW'(VOICE_COUNT - 1));
    st.atk_need   = (cur_elapsed < 32'(ram_q.rise));
    st.rel_need   = (ram_q.remaining < 32'(ram_q.fall));
    st.div_last   = (cnt_r == 6'd62);
    st.ask_more   = voice_ok && (k_r < cur_cnt);
    st.out_free   = !out_valid_r || !out_stall;
  end

endmodule

`default_nettype wire

### rtl/core/multi_voice_tone_synthesizer_top.sv
// multi-voice tone synthesizer: top level joining controller and datapath
// depends on mvts_pkg, mvts_ctrl, mvts_dpath
//
// usage:
//   input channel in_valid/in_stall/in_item carries ticks and commands; the
//   output channel out_valid/out_stall/out_item carries stereo samples,
//   time-left answers and queue-full errors. one item is worked at a time.
//   a tick walks every voice: an idle voice is skipped; a sounding voice is
//   read, scaled by the sine table and gain, then by the shared bit-serial
//   divider for each active attack or release scale, then panned and summed.
//   add and replace may end in a queue-full error; end, clear all and unused
//   actions give no result; a time-left question does one note ram read
//   per queued note.
//   a result sits in an output register; while it is stalled the block keeps
//   working on the next item and holds only when that item's result is ready.
//   reset is synchronous, active low: every voice is silent and empty; note
//   slots hold garbage until written, no clearing pass is needed.
`default_nettype none

module multi_voice_tone_synthesizer_top #(
  parameter int VOICE_COUNT     = 8,
  parameter int QUEUE_DEPTH     = 8,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mvts_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mvts_pkg::out_item_t      out_item
);
  import mvts_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  mvts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mvts_dpath #(
    .VOICE_COUNT     (VOICE_COUNT),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

### test/multi_voice_tone_synthesizer_top_test.sv
// testbench for the multi-voice tone synthesizer top level
// drives ticks and note commands, predicts every result, checks item by item
// depends on mvts_pkg and multi_voice_tone_synthesizer_top
`timescale 1ns / 100ps

module multi_voice_tone_synthesizer_top_test;
  import mvts_pkg::*;

  localparam int VOICES = 8;
  localparam int DEPTH = 8;
  localparam int TABLE_SIZE = 1024;
  localparam int CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  multi_voice_tone_synthesizer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #4 clk = ~clk;

  // synthesizer state mirror
  slot_t notes [VOICES*DEPTH];
  logic [2:0] head [VOICES];
  logic [3:0] count [VOICES];
  logic [31:0] phase [VOICES];
  logic [31:0] elapsed [VOICES];

  in_item_t pending [$];
  out_item_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  bit stimulus_done = 1'b0;
  bit hold_request = 1'b0;
  bit long_hold = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint sine_value(longint idx);
    longint q, quad, rem, x, x2, term, acc;
    q = (idx % TABLE_SIZE) * 4;
    quad = q / TABLE_SIZE;
    rem = q % TABLE_SIZE;
    x = (((quad & 1) != 0) ? (TABLE_SIZE - rem) : rem) * 1686629711 / TABLE_SIZE;
    x2 = (x * x) >>> 30;
    term = x;
    acc = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
      if (k & 1) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    acc = (acc + (1 << 14)) >>> 15;
    if (acc > 32767) acc = 32767;
    return (quad >= 2) ? -acc : acc;
  endfunction

  function automatic int slot_index(int v, int k);
    return v * DEPTH + (int'(head[v]) + k) % DEPTH;
  endfunction

  function automatic logic [23:0] clamp24(longint x);
    if (x > 8388607) x = 8388607;
    if (x < -8388608) x = -8388608;
    return x[23:0];
  endfunction

  function automatic void cut_to_release(int v);
    int s;
    if (count[v] > 0) begin
      s = slot_index(v, 0);
      if (notes[s].fall < notes[s].remaining) notes[s].remaining = notes[s].fall;
      count[v] = 1;
    end
  endfunction

  function automatic out_item_t mix_sample();
    out_item_t r;
    longint lsum, rsum, amp, bal, cl, cr;
    logic [63:0] mag;
    bit neg;
    int s;
    lsum = 0;
    rsum = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (count[v] != 0) begin
        s = slot_index(v, 0);
        amp = sine_value((longint'(phase[v]) * TABLE_SIZE) >>> 32) * longint'(notes[s].gain);
        neg = amp < 0;
        mag = neg ? -amp : amp;
        if (elapsed[v] < notes[s].rise) mag = mag * elapsed[v] / notes[s].rise;
        if (notes[s].remaining < notes[s].fall) mag = mag * notes[s].remaining / notes[s].fall;
        bal = notes[s].balance;
        cl = longint'((mag * 64'(32768 - bal)) >> 23);
        cr = longint'((mag * 64'(32768 + bal)) >> 23);
        lsum += neg ? -cl : cl;
        rsum += neg ? -cr : cr;
        phase[v] += notes[s].phase_step;
        if (elapsed[v] != 32'hFFFF_FFFF) elapsed[v]++;
        if (notes[s].remaining <= 1) begin
          head[v] = head[v] + 3'd1;
          count[v]--;
          phase[v] = 0;
          elapsed[v] = 0;
        end else begin
          notes[s].remaining--;
        end
      end
    end
    r = '0;
    r.kind = KIND_SAMPLE;
    r.left_sample = clamp24(lsum);
    r.right_sample = clamp24(rsum);
    return r;
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t r;
    int v, s;
    logic [63:0] total;
    v = it.voice;
    r = '0;
    case (it.action)
      ACT_TICK: expected_results = {expected_results, mix_sample()};
      ACT_ADD, ACT_REPLACE: begin
        if (it.action == ACT_REPLACE) cut_to_release(v);
        if (it.length_samples != 0) begin
          if (count[v] >= DEPTH) begin
            r.kind = KIND_FULL;
            expected_results = {expected_results, r};
          end else begin
            s = slot_index(v, count[v]);
            notes[s] = '{phase_step: it.phase_step, gain: it.note_gain,
                         balance: it.balance, remaining: it.length_samples,
                         rise: it.rise_samples, fall: it.fall_samples};
            if (count[v] == 0) begin
              phase[v] = 0;
              elapsed[v] = 0;
            end
            count[v]++;
          end
        end
      end
      ACT_END: cut_to_release(v);
      ACT_CLEAR: begin
        for (int k = 0; k < VOICES; k++) begin
          head[k] = 0;
          count[k] = 0;
          phase[k] = 0;
          elapsed[k] = 0;
        end
      end
      ACT_ASK: begin
        total = 0;
        for (int k = 0; k < count[v]; k++) total += notes[slot_index(v, k)].remaining;
        if (total > 64'hF_FFFF_FFFF) total = 64'hF_FFFF_FFFF;
        r.kind = KIND_TIME;
        r.remaining_total = total[35:0];
        expected_results = {expected_results, r};
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t make_note(logic [2:0] act, int v, logic [31:0] len,
                                         logic [23:0] rise, logic [23:0] fall);
    in_item_t it;
    it.action = act;
    it.voice = 3'(v);
    it.phase_step = 31'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 50000000));
    it.note_gain = 16'($urandom);
    it.balance = 16'($urandom);
    it.length_samples = len;
    it.rise_samples = rise;
    it.fall_samples = fall;
    return it;
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] act, int v);
    in_item_t it;
    it = '0;
    it.action = act;
    it.voice = 3'(v);
    it.phase_step = 31'($urandom);
    it.length_samples = $urandom;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(in_item);
        pending.delete(0);
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 1)) send_gap = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $time, out_item);
        end else begin
          if (expected_results[0].kind != out_item.kind ||
              expected_results[0].left_sample != out_item.left_sample ||
              expected_results[0].right_sample != out_item.right_sample ||
              expected_results[0].remaining_total != out_item.remaining_total) begin
            errors++;
            $display("%0t mismatch expected %h actual %h", $time,
                     expected_results[0], out_item);
          end
          expected_results.delete(0);
        end
        recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_request);
    long_hold = 1'b1;
    repeat (3000) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    int v, n, sel;
    for (int k = 0; k < VOICES; k++) begin
      head[k] = 0; count[k] = 0; phase[k] = 0; elapsed[k] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: silent tick, extremes, full queue, every command
    pending = {pending, make_cmd(ACT_TICK, 0)};
    pending = {pending, make_note(ACT_ADD, 0, 32'd3, 24'd0, 24'd0)};
    pending[$].note_gain = 16'hFFFF;
    pending[$].balance = 16'sh8000;
    pending[$].phase_step = 31'h7FFF_FFFF;
    pending = {pending, make_note(ACT_ADD, 1, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF)};
    pending[$].balance = 16'sh7FFF;
    pending[$].note_gain = 16'hFFFF;
    pending = {pending, make_note(ACT_ADD, 2, 32'd0, 24'd1, 24'd1)};
    for (int k = 0; k < 3; k++) pending = {pending, make_cmd(ACT_TICK, 0)};
    for (int k = 0; k < 9; k++)
      pending = {pending, make_note(ACT_ADD, 7, 32'hFFFF_FFF0, 24'd4, 24'd2)};
    pending = {pending, make_cmd(ACT_ASK, 7)};
    pending = {pending, make_cmd(ACT_ASK, 1)};
    pending = {pending, make_cmd(ACT_END, 7)};
    pending = {pending, make_note(ACT_REPLACE, 1, 32'd0, 24'd0, 24'd0)};
    pending = {pending, make_cmd(ACT_TICK, 0)};
    pending = {pending, make_cmd(ACT_TICK, 0)};
    pending = {pending, make_cmd(3'd6, 1)};
    pending = {pending, make_cmd(3'd7, 2)};
    pending = {pending, make_cmd(ACT_CLEAR, 0)};
    pending = {pending, make_cmd(ACT_ASK, 7)};
    // random: mostly short notes and ticks
    for (int k = 0; k < 1420; k++) begin
      if (k == 700) hold_request = 1'b1;
      v = $urandom_range(0, VOICES - 1);
      sel = $urandom_range(0, 99);
      n = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(0, 40);
      if (sel < 50) pending = {pending, make_cmd(ACT_TICK, v)};
      else if (sel < 72) pending = {pending, make_note(ACT_ADD, v, n,
               24'($urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 10)),
               24'($urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 10)))};
      else if (sel < 78) pending = {pending, make_note(ACT_REPLACE, v, n,
               24'($urandom_range(0, 10)), 24'($urandom_range(0, 10)))};
      else if (sel < 84) pending = {pending, make_cmd(ACT_END, v)};
      else if (sel < 86) pending = {pending, make_cmd(ACT_CLEAR, v)};
      else if (sel < 96) pending = {pending, make_cmd(ACT_ASK, v)};
      else pending = {pending, make_cmd(3'(3'd6 + $urandom_range(0, 1)), v)};
      while (pending.size() > 8) @(posedge clk);
    end
    while (pending.size() > 0) @(posedge clk);
    stimulus_done = 1'b1;
  end

  initial begin
    while (!(stimulus_done && expected_results.size() == 0)) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
